// File: rtl/core/mire_pkg.sv
// ----------------------------------------------------------------------------
// mire_pkg: shared types and constants of the median interval rate estimator
// Request and result payloads, the cell control group and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mire_pkg;

  localparam int unsigned FIELD_WIDTH = 48;
  localparam logic [FIELD_WIDTH-1:0] RATE_RESET = 48'd1000000000;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] timestamp;
    logic                   finite;
    logic                   last;
  } request_t;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] frequency;
    logic                   found;
    logic                   overflowed;
  } result_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/mire_cell.sv
// ----------------------------------------------------------------------------
// mire_cell: one cell of the sorting chain
// Keeps the smaller of its held and incoming interval and passes the larger
// one to the right; in shift mode it takes the value of its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module mire_cell
  import mire_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cell_ctrl_t            ctrl,
  input  wire logic                  in_valid,
  input  wire logic [TIME_WIDTH-1:0] in_data,
  input  wire logic                  nb_valid,
  input  wire logic [TIME_WIDTH-1:0] nb_data,
  output logic                       out_valid,
  output logic [TIME_WIDTH-1:0]      out_data,
  output logic                       held_valid,
  output logic [TIME_WIDTH-1:0]      held_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (ctrl.clear) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (ctrl.shift) begin
      held_valid <= nb_valid;
      held_data  <= nb_data;
      out_valid  <= 1'b0;
    end else if (in_valid) begin
      if (!held_valid) begin
        held_valid <= 1'b1;
        held_data  <= in_data;
        out_valid  <= 1'b0;
      end else if (in_data < held_data) begin
        held_data <= in_data;
        out_data  <= held_data;
        out_valid <= 1'b1;
      end else begin
        out_data  <= in_data;
        out_valid <= 1'b1;
      end
    end else begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mire_divider.sv
// ----------------------------------------------------------------------------
// mire_divider: restoring divider, one quotient bit per cycle
// Divides the 48-bit rate numerator by the median interval.
// ----------------------------------------------------------------------------
`default_nettype none

module mire_divider
  import mire_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   go,
  input  wire logic [FIELD_WIDTH-1:0] dividend,
  input  wire logic [TIME_WIDTH-1:0]  divisor,
  output logic                        done,
  output logic [FIELD_WIDTH-1:0]      quotient
);

  localparam int unsigned SW = $clog2(FIELD_WIDTH + 1);

  logic [SW-1:0]         steps;
  logic                  running;
  logic [TIME_WIDTH-1:0] rem;
  logic [TIME_WIDTH:0]   rem_sh;
  logic [TIME_WIDTH:0]   rem_sub;
  logic                  fits;

  assign rem_sh  = {rem, quotient[FIELD_WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign fits    = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running  <= 1'b1;
        steps    <= SW'(FIELD_WIDTH);
        rem      <= '0;
        quotient <= dividend;
      end else if (running) begin
        if (fits) begin
          rem      <= rem_sub[TIME_WIDTH-1:0];
          quotient <= {quotient[FIELD_WIDTH-2:0], 1'b1};
        end else begin
          rem      <= rem_sh[TIME_WIDTH-1:0];
          quotient <= {quotient[FIELD_WIDTH-2:0], 1'b0};
        end
        steps <= steps - SW'(1);
        if (steps == SW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/median_interval_rate_estimator_unit.sv
// ----------------------------------------------------------------------------
// median_interval_rate_estimator_unit: rate from the median sample interval
// Sorts positive timestamp differences in a chain of cells, picks the upper
// median and divides the rate numerator by it at the end of each set.
// ----------------------------------------------------------------------------
//  channel   ports                           handshake
//  request   start, busy, request            taken when start and not busy
//  result    done, result                    one-cycle strobe, no back-pressure
//  config    cfg_valid, cfg_ready, cfg_data  written when valid and ready
//
// While a set loads, one request is taken every cycle.
// After a request marked last, busy stays high while the chain of kept
// intervals settles, the chain shifts to the median, the 48-step divider is
// started, run and collected, and the result is reported.
// Reset is synchronous and clears the set; the configuration register
// returns to its reset value. The result side cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module median_interval_rate_estimator_unit
  import mire_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = 1024,
  parameter int unsigned TIME_WIDTH    = 48
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire request_t               request,
  output logic                        done,
  output result_t                     result,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [FIELD_WIDTH-1:0] cfg_data
);

  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_INTERVALS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SETTLE = 5'b00010,
    S_SELECT = 5'b00100,
    S_DIVIDE = 5'b01000,
    S_REPORT = 5'b10000
  } state_t;

  state_t                 state;
  logic [FIELD_WIDTH-1:0] rate_numerator;
  logic [TIME_WIDTH-1:0]  prev_time;
  logic                   prev_usable;
  logic [CW-1:0]          count;
  logic [CW-1:0]          timer;
  logic                   overflow_seen;
  logic                   feed_valid;
  logic [TIME_WIDTH-1:0]  feed_data;
  logic                   div_go;
  logic                   div_done;
  logic [FIELD_WIDTH-1:0] quotient;
  result_t                result_reg;

  logic                               accept;
  logic [FIELD_WIDTH+TIME_WIDTH-1:0]  ts_ext;
  logic [TIME_WIDTH-1:0]              ts;
  logic                               usable;
  logic                               room;
  logic [CW-1:0]                      median_index;
  cell_ctrl_t                         ctrl;

  logic                  fwd_valid  [0:MAX_INTERVALS];
  logic [TIME_WIDTH-1:0] fwd_data   [0:MAX_INTERVALS];
  logic                  held_valid [0:MAX_INTERVALS];
  logic [TIME_WIDTH-1:0] held_data  [0:MAX_INTERVALS];

  assign accept       = start && !busy;
  assign ts_ext       = {{TIME_WIDTH{1'b0}}, request.timestamp};
  assign ts           = ts_ext[TIME_WIDTH-1:0];
  assign usable       = request.finite && prev_usable && (ts > prev_time);
  assign room         = count < MAX_COUNT;
  assign median_index = count >> 1;
  assign busy         = (state != S_IDLE);
  assign done         = (state == S_REPORT);
  assign result       = result_reg;
  assign cfg_ready    = 1'b1;

  assign ctrl.shift = (state == S_SELECT) && (timer != median_index);
  assign ctrl.clear = (state == S_REPORT);

  assign fwd_valid[0]              = feed_valid;
  assign fwd_data[0]               = feed_data;
  assign held_valid[MAX_INTERVALS] = 1'b0;
  assign held_data[MAX_INTERVALS]  = '0;

  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    mire_cell #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .in_valid   (fwd_valid[i]),
      .in_data    (fwd_data[i]),
      .nb_valid   (held_valid[i+1]),
      .nb_data    (held_data[i+1]),
      .out_valid  (fwd_valid[i+1]),
      .out_data   (fwd_data[i+1]),
      .held_valid (held_valid[i]),
      .held_data  (held_data[i])
    );
  end

  mire_divider #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (rate_numerator),
    .divisor  (held_data[0]),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_numerator <= RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rate_numerator <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      prev_usable   <= 1'b0;
      prev_time     <= '0;
      count         <= '0;
      timer         <= '0;
      overflow_seen <= 1'b0;
      feed_valid    <= 1'b0;
      div_go        <= 1'b0;
    end else begin
      feed_valid <= 1'b0;
      div_go     <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            prev_time   <= request.finite ? ts : '0;
            prev_usable <= request.finite;
            if (usable) begin
              if (room) begin
                feed_valid <= 1'b1;
                feed_data  <= ts - prev_time;
                count      <= count + CW'(1);
              end else begin
                overflow_seen <= 1'b1;
              end
            end
            if (request.last) begin
              timer <= '0;
              state <= S_SETTLE;
            end
          end
        end
        S_SETTLE: begin
          if (timer == count) begin
            timer <= '0;
            state <= S_SELECT;
          end else begin
            timer <= timer + CW'(1);
          end
        end
        S_SELECT: begin
          if (timer == median_index) begin
            div_go <= 1'b1;
            state  <= S_DIVIDE;
          end else begin
            timer <= timer + CW'(1);
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            result_reg.frequency  <= (count != '0) ? quotient : '0;
            result_reg.found      <= (count != '0);
            result_reg.overflowed <= overflow_seen;
            state                 <= S_REPORT;
          end
        end
        S_REPORT: begin
          prev_time     <= '0;
          prev_usable   <= 1'b0;
          count         <= '0;
          overflow_seen <= 1'b0;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mire_checker.sv
// ----------------------------------------------------------------------------
// mire_checker: port-level checks of the median interval rate estimator
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module mire_checker
  import mire_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire request_t request,
  input wire logic     done,
  input wire result_t  result
);

  // A result appears only while a set is being finished.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a busy phase");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // A request that does not end the set leaves the unit ready for the next.
  a_stream: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !request.last) |=> !busy)
    else $error("unit stalled within a set");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.last) |=> busy)
    else $error("last request did not start the estimate");

  a_not_found: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.frequency == '0))
    else $error("frequency nonzero without a usable interval");

endmodule

bind median_interval_rate_estimator_unit mire_checker u_mire_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the median interval rate estimator
// Timestamp sets of varied shape go in, and a scoreboard predicts the rate
// estimate from the upper median of the kept intervals for every set.
// ----------------------------------------------------------------------------

module tb_top;
  import mire_pkg::*;

  localparam int unsigned MAX_KEPT = 1024;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [FIELD_WIDTH-1:0] FIELD_MAX = '1;

  class rate_scoreboard;
    logic [FIELD_WIDTH-1:0] rate;
    logic [FIELD_WIDTH-1:0] prev_time;
    bit                     have_prev;
    bit                     dropped;
    logic [FIELD_WIDTH-1:0] sorted_intervals[$];
    result_t                expected_estimates[$];
    int                     errors;

    function new();
      rate = RATE_RESET;
      prev_time = '0;
      have_prev = 1'b0;
      dropped = 1'b0;
      errors = 0;
    endfunction

    function void set_rate(logic [FIELD_WIDTH-1:0] value);
      rate = value;
    endfunction

    function void note_request(request_t req);
      logic [FIELD_WIDTH-1:0] gap;
      logic [FIELD_WIDTH-1:0] median;
      result_t                est;
      int                     pos;
      if (req.finite && have_prev && req.timestamp > prev_time) begin
        gap = req.timestamp - prev_time;
        if (sorted_intervals.size() >= MAX_KEPT) begin
          dropped = 1'b1;
        end else begin
          pos = sorted_intervals.size();
          while (pos > 0 && sorted_intervals[pos-1] > gap) pos--;
          sorted_intervals.insert(pos, gap);
        end
      end
      prev_time = req.finite ? req.timestamp : '0;
      have_prev = req.finite;
      if (!req.last) return;
      est = '0;
      if (sorted_intervals.size() > 0) begin
        median = sorted_intervals[sorted_intervals.size() / 2];
        if (median != 0) begin
          est.frequency = rate / median;
          est.found = 1'b1;
        end
      end
      est.overflowed = dropped;
      expected_estimates.push_back(est);
      sorted_intervals.delete();
      prev_time = '0;
      have_prev = 1'b0;
      dropped = 1'b0;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_estimates.size() == 0) begin
        $error("unexpected result: frequency %0d found %0b overflowed %0b",
               got.frequency, got.found, got.overflowed);
        errors++;
        return;
      end
      want = expected_estimates.pop_front();
      if (got.frequency !== want.frequency) begin
        $error("frequency: expected %0d, actual %0d", want.frequency, got.frequency);
        errors++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0b, actual %0b", want.found, got.found);
        errors++;
      end
      if (got.overflowed !== want.overflowed) begin
        $error("overflowed: expected %0b, actual %0b", want.overflowed, got.overflowed);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  request_t               request = '0;
  logic                   done;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [FIELD_WIDTH-1:0] cfg_data = '0;

  rate_scoreboard sb;
  int unsigned    cycle_count = 0;
  int unsigned    burst_left = 0;
  bit             steady = 1'b0;
  int unsigned    random_items = 0;
  int unsigned    set_count = 0;

  median_interval_rate_estimator_unit #(
    .MAX_INTERVALS(MAX_KEPT),
    .TIME_WIDTH   (FIELD_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [FIELD_WIDTH-1:0] rand48();
    return FIELD_WIDTH'({$urandom(), $urandom()});
  endfunction

  // Requests go out in bursts; a gap with start low opens between bursts
  // unless the sender is in a steady stretch.
  task automatic send(input logic [FIELD_WIDTH-1:0] ts, input bit fin, input bit is_last);
    request_t req;
    req.timestamp = ts;
    req.finite = fin;
    req.last = is_last;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    request <= req;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_request(req);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_estimates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(input logic [FIELD_WIDTH-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.set_rate(value);
    cfg_valid <= 1'b0;
  endtask

  // Most sets are rising finite timestamps with a few broken samples mixed
  // in; the rest are loose noise.
  task automatic random_set(input int unsigned len);
    logic [FIELD_WIDTH-1:0] t;
    logic [FIELD_WIDTH-1:0] step_max;
    bit                     clean;
    bit                     is_last;
    clean = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 3))
      0: step_max = 48'd16;
      1: step_max = 48'hFFFF;
      2: step_max = 48'hFFFF_FFFF;
      default: step_max = 48'h0FFF_FFFF_FFFF;
    endcase
    t = clean ? rand48() >> $urandom_range(1, 40) : rand48();
    for (int unsigned i = 0; i < len; i++) begin
      is_last = (i == len - 1);
      if (clean && $urandom_range(0, 9) != 0) begin
        t = t + (rand48() % step_max) + 1;
        send(t, 1'b1, is_last);
      end else begin
        case ($urandom_range(0, 3))
          0: send(rand48(), 1'b0, is_last);
          1: send(t, 1'b1, is_last);
          2: begin
            t = t - (rand48() % step_max);
            send(t, 1'b1, is_last);
          end
          default: begin
            t = rand48();
            send(t, 1'($urandom_range(0, 1)), is_last);
          end
        endcase
      end
      random_items++;
    end
  endtask

  task automatic long_set(input int unsigned len);
    logic [FIELD_WIDTH-1:0] t;
    t = rand48() >> 8;
    for (int unsigned i = 0; i < len; i++) begin
      t = t + $urandom_range(1, 3);
      send(t, 1'b1, i == len - 1);
      random_items++;
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(48'd77, 1'b1, 1'b1);
    send(48'd0, 1'b1, 1'b0);
    send(FIELD_MAX, 1'b1, 1'b1);
    send(48'd100, 1'b1, 1'b0);
    send(48'd101, 1'b1, 1'b1);
    send(48'd10, 1'b1, 1'b0);
    send(48'd20, 1'b0, 1'b0);
    send(48'd30, 1'b1, 1'b0);
    send(48'd45, 1'b1, 1'b1);
    send(48'd50, 1'b1, 1'b0);
    send(48'd50, 1'b1, 1'b0);
    send(48'd40, 1'b1, 1'b0);
    send(48'd60, 1'b1, 1'b1);
    send(48'd0, 1'b1, 1'b0);
    send(48'd10, 1'b1, 1'b0);
    send(48'd30, 1'b1, 1'b0);
    send(48'd60, 1'b1, 1'b0);
    send(48'd100, 1'b1, 1'b1);
    send(48'd5, 1'b1, 1'b0);
    send(48'd9, 1'b1, 1'b0);
    send(FIELD_MAX, 1'b0, 1'b1);
    write_rate('0);
    send(48'd1000, 1'b1, 1'b0);
    send(48'd1003, 1'b1, 1'b1);
    write_rate(FIELD_MAX);
    send(FIELD_MAX - 1, 1'b1, 1'b0);
    send(FIELD_MAX, 1'b1, 1'b1);

    while (random_items < RANDOM_ITEMS) begin
      if (set_count % 15 == 0) begin
        case ($urandom_range(0, 4))
          0: write_rate(48'd1);
          1: write_rate(FIELD_MAX);
          2: write_rate(rand48());
          3: write_rate(rand48() >> $urandom_range(1, 47));
          default: write_rate(RATE_RESET);
        endcase
      end
      if (set_count == 10) long_set(MAX_KEPT + 6);
      if (set_count == 70) drain();
      steady = ($urandom_range(0, 4) == 0);
      random_set(($urandom_range(0, 7) == 0) ? $urandom_range(11, 60) : $urandom_range(1, 10));
      set_count++;
    end

    drain();
    if (sb.errors == 0 && sb.expected_estimates.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mire_pkg.sv
rtl/core/mire_cell.sv
rtl/core/mire_divider.sv
rtl/core/median_interval_rate_estimator_unit.sv
rtl/core/mire_checker.sv
dv/tb_top.sv
